[hdl/tfn_pkg.sv]
// ---------------------------------------------------------------------------
// tfn_pkg: shared types and constants of the triangle face normal block
// Request and result payloads, the command passed from the front end to the
// back end, and the status and opcode values.
// ---------------------------------------------------------------------------
package tfn_pkg;

  localparam int IN_COORD_W = 24;
  localparam int IDX_W      = 16;
  localparam int ADDR_IN_W  = 12;
  localparam int NORM_W     = 16;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TRI  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Q2.14 one
  localparam logic [NORM_W-1:0] NORM_ONE = 16'd16384;

  typedef struct packed {
    logic                         op;
    logic [ADDR_IN_W-1:0]         vertex_addr;
    logic signed [IN_COORD_W-1:0] coord_x;
    logic signed [IN_COORD_W-1:0] coord_y;
    logic signed [IN_COORD_W-1:0] coord_z;
    logic [IDX_W-1:0]             index_first;
    logic [IDX_W-1:0]             index_second;
    logic [IDX_W-1:0]             index_third;
    logic                         last_triangle;
  } tfn_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [1:0]               status;
    logic                     last_normal;
  } tfn_out_t;

  // command from front end to back end; addresses are 0-based
  typedef struct packed {
    logic                         is_tri;
    logic [1:0]                   status;
    logic                         last;
    logic [IDX_W-1:0]             addr0;
    logic [IDX_W-1:0]             addr1;
    logic [IDX_W-1:0]             addr2;
    logic signed [IN_COORD_W-1:0] cx;
    logic signed [IN_COORD_W-1:0] cy;
    logic signed [IN_COORD_W-1:0] cz;
  } tfn_cmd_t;

endpackage

[hdl/tfn_front.sv]
// ---------------------------------------------------------------------------
// tfn_front: request classifier
// Decodes a request into a load or triangle command: winding swap, index
// range check, 0-based addresses and coordinate narrowing.
// ---------------------------------------------------------------------------
module tfn_front import tfn_pkg::*; #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_BITS   = 24
) (
  input  tfn_in_t  req,
  input  logic     flip,
  output tfn_cmd_t cmd,
  output logic     keep
);

  localparam int CW = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int SH = IN_COORD_W - CW;
  localparam logic [IDX_W:0] DEPTH_W = (IDX_W+1)'(VERTEX_DEPTH);

  logic [IDX_W-1:0] i0, i1, i2;
  logic             bad;
  logic             is_tri;

  // keep the low CW bits, sign extended
  function automatic logic signed [IN_COORD_W-1:0] narrow(
    input logic signed [IN_COORD_W-1:0] c);
    logic signed [IN_COORD_W-1:0] t;
    t = c <<< SH;
    return t >>> SH;
  endfunction

  // winding and range check
  always_comb begin
    i0 = flip ? req.index_third : req.index_first;
    i1 = req.index_second;
    i2 = flip ? req.index_first : req.index_third;
    bad = (i0 == '0) || ({1'b0, i0} > DEPTH_W) ||
          (i1 == '0) || ({1'b0, i1} > DEPTH_W) ||
          (i2 == '0) || ({1'b0, i2} > DEPTH_W);
  end

  // command build
  always_comb begin
    is_tri     = (req.op == OP_TRI);
    cmd.is_tri = is_tri;
    cmd.status = bad ? ST_BAD : ST_OK;
    cmd.last   = req.last_triangle;
    cmd.addr0  = is_tri ? i0 - 1'b1 : IDX_W'(req.vertex_addr);
    cmd.addr1  = i1 - 1'b1;
    cmd.addr2  = i2 - 1'b1;
    cmd.cx     = narrow(req.coord_x);
    cmd.cy     = narrow(req.coord_y);
    cmd.cz     = narrow(req.coord_z);
    // loads beyond the store are dropped
    keep = is_tri || ({(IDX_W+1-ADDR_IN_W)'(0), req.vertex_addr} < DEPTH_W);
  end

endmodule

[hdl/tfn_queue.sv]
// ---------------------------------------------------------------------------
// tfn_queue: two-entry command queue
// Decouples the front end from the back end so each side stalls on its own.
// ---------------------------------------------------------------------------
module tfn_queue import tfn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tfn_cmd_t din,
  output logic     full,
  input  logic     pop,
  output tfn_cmd_t dout,
  output logic     empty
);

  tfn_cmd_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= din;
  end

endmodule

[hdl/tfn_back.sv]
// ---------------------------------------------------------------------------
// tfn_back: vertex store and normal pipeline
// Three store banks give one vertex each per cycle; cross product, block
// normalization, a pipelined square root and three pipelined dividers follow.
// ---------------------------------------------------------------------------
module tfn_back import tfn_pkg::*; #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_BITS   = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  tfn_cmd_t cmd,
  output logic     cmd_pop,
  output logic     res_valid,
  output tfn_out_t res,
  input  logic     res_pop
);

  localparam int CW   = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int AW   = $clog2(VERTEX_DEPTH);
  localparam int DW   = CW + 1;        // edge vector
  localparam int PWID = 2 * CW + 2;    // partial product
  localparam int NW   = 2 * CW + 3;    // cross product
  localparam int UW   = 30;            // normalized magnitude
  localparam int SQW  = 62;            // sum of squares
  localparam int SQN  = 31;            // root bits
  localparam int RW   = 31;
  localparam int DVW  = 46;            // dividend
  localparam int DDW  = RW + 1;        // divisor 2r
  localparam int QB   = 16;            // quotient bits
  localparam logic [5:0] MSB_POS = 6'd29;

  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic [2:0] neg;
  } meta_t;

  logic adv;
  assign adv     = !res_valid || res_pop;
  assign cmd_pop = adv && cmd_valid;

  // vertex store: one bank per triangle corner
  logic [3*CW-1:0] mem_a [VERTEX_DEPTH];
  logic [3*CW-1:0] mem_b [VERTEX_DEPTH];
  logic [3*CW-1:0] mem_c [VERTEX_DEPTH];
  logic [3*CW-1:0] rd_a_r, rd_b_r, rd_c_r;
  logic            wr_en;
  logic [3*CW-1:0] wr_data;
  logic            v1_r;
  meta_t           m1_r;

  assign wr_en   = cmd_pop && !cmd.is_tri;
  assign wr_data = {cmd.cz[CW-1:0], cmd.cy[CW-1:0], cmd.cx[CW-1:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_en) begin
        mem_a[cmd.addr0[AW-1:0]] <= wr_data;
        mem_b[cmd.addr0[AW-1:0]] <= wr_data;
        mem_c[cmd.addr0[AW-1:0]] <= wr_data;
      end
      rd_a_r <= mem_a[cmd.addr0[AW-1:0]];
      rd_b_r <= mem_b[cmd.addr1[AW-1:0]];
      rd_c_r <= mem_c[cmd.addr2[AW-1:0]];
      m1_r   <= '{status: cmd.status, last: cmd.last, neg: 3'b000};
    end
  end

  // edge vectors a = v2 - v1, b = v3 - v1
  logic signed [DW-1:0] a_r [3];
  logic signed [DW-1:0] b_r [3];
  logic                 v2_r;
  meta_t                m2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a_r[k] <= DW'($signed(rd_b_r[k*CW +: CW])) - DW'($signed(rd_a_r[k*CW +: CW]));
        b_r[k] <= DW'($signed(rd_c_r[k*CW +: CW])) - DW'($signed(rd_a_r[k*CW +: CW]));
      end
      m2_r <= m1_r;
    end
  end

  // partial products of n = b x a
  logic signed [PWID-1:0] pr_r [6];
  logic                   v3_r;
  meta_t                  m3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r[0] <= PWID'(b_r[1]) * PWID'(a_r[2]);
      pr_r[1] <= PWID'(b_r[2]) * PWID'(a_r[1]);
      pr_r[2] <= PWID'(b_r[2]) * PWID'(a_r[0]);
      pr_r[3] <= PWID'(b_r[0]) * PWID'(a_r[2]);
      pr_r[4] <= PWID'(b_r[0]) * PWID'(a_r[1]);
      pr_r[5] <= PWID'(b_r[1]) * PWID'(a_r[0]);
      m3_r    <= m2_r;
    end
  end

  // cross product
  logic signed [NW-1:0] n_r [3];
  logic                 v4_r;
  meta_t                m4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++)
        n_r[k] <= NW'(pr_r[2*k]) - NW'(pr_r[2*k+1]);
      m4_r <= m3_r;
    end
  end

  // magnitudes and signs
  logic [NW-1:0] u_r [3];
  logic          v5_r;
  meta_t         m5_r;
  meta_t         m5_nxt;

  always_comb begin
    m5_nxt = m4_r;
    for (int k = 0; k < 3; k++) m5_nxt.neg[k] = n_r[k][NW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++)
        u_r[k] <= n_r[k][NW-1] ? NW'(-n_r[k]) : NW'(n_r[k]);
      m5_r <= m5_nxt;
    end
  end

  // largest magnitude, two compares over two stages
  logic [NW-1:0] m01_r, mx_r;
  logic [NW-1:0] u6_r [3];
  logic [NW-1:0] u7_r [3];
  logic          v6_r, v7_r;
  meta_t         m6_r, m7_r, m7_nxt;

  always_comb begin
    m7_nxt = m6_r;
    if (m6_r.status == ST_OK && m01_r == '0 && u6_r[2] == '0) m7_nxt.status = ST_DEGEN;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m01_r <= (u_r[0] > u_r[1]) ? u_r[0] : u_r[1];
      u6_r  <= u_r;
      m6_r  <= m5_r;
      mx_r  <= (m01_r > u6_r[2]) ? m01_r : u6_r[2];
      u7_r  <= u6_r;
      m7_r  <= m7_nxt;
    end
  end

  // leading one of the maximum gives the block shift
  logic [5:0]    lead;
  logic [5:0]    sr_r, sl_r;
  logic [NW-1:0] u8_r [3];
  logic          v8_r;
  meta_t         m8_r;

  always_comb begin
    lead = '0;
    for (int i = 0; i < NW; i++)
      if (mx_r[i]) lead = 6'(i);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_r <= (lead > MSB_POS) ? lead - MSB_POS : 6'd0;
      sl_r <= (lead < MSB_POS) ? MSB_POS - lead : 6'd0;
      u8_r <= u7_r;
      m8_r <= m7_r;
    end
  end

  // block shift so the largest lands in [2^29, 2^30)
  logic [UW-1:0]    un_r [3];
  logic [NW+UW-1:0] shf [3];
  logic             v9_r;
  meta_t            m9_r;

  always_comb begin
    for (int k = 0; k < 3; k++)
      shf[k] = ((NW+UW)'(u8_r[k]) >> sr_r) << sl_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) un_r[k] <= shf[k][UW-1:0];
      m9_r <= m8_r;
    end
  end

  // squares
  logic [2*UW-1:0] sq_r [3];
  logic [UW-1:0]   un10_r [3];
  logic            v10_r;
  meta_t           m10_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++)
        sq_r[k] <= (2*UW)'(un_r[k]) * (2*UW)'(un_r[k]);
      un10_r <= un_r;
      m10_r  <= m9_r;
    end
  end

  // square root pipeline, one root bit per stage; index 0 holds the sum
  logic [SQW-1:0] sx_r   [SQN+1];
  logic [SQW-1:0] sres_r [SQN+1];
  logic [UW-1:0]  sun_r  [SQN+1][3];
  logic           sv_r   [SQN+1];
  meta_t          sm_r   [SQN+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r[0]   <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
      sres_r[0] <= '0;
      sun_r[0]  <= un10_r;
      sm_r[0]   <= m10_r;
    end
  end

  for (genvar s = 0; s < SQN; s++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQN - 1 - s));
    logic [SQW:0] trial;
    logic         ge;
    assign trial = {1'b0, sres_r[s]} + {1'b0, BIT};
    assign ge    = ({1'b0, sx_r[s]} >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        sx_r[s+1]   <= ge ? sx_r[s] - trial[SQW-1:0] : sx_r[s];
        sres_r[s+1] <= ge ? (sres_r[s] >> 1) + BIT : sres_r[s] >> 1;
        sun_r[s+1]  <= sun_r[s];
        sm_r[s+1]   <= sm_r[s];
      end
    end
  end

  // divider setup: q = (u * 32768 + r) / (2r)
  logic [RW-1:0]  root;
  logic [DVW-1:0] drem_r [QB+1][3];
  logic [QB-1:0]  dq_r   [QB+1][3];
  logic [DDW-1:0] dd_r   [QB+1];
  logic           dv_r   [QB+1];
  meta_t          dm_r   [QB+1];

  assign root = sres_r[SQN][RW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        drem_r[0][k] <= {1'b0, sun_r[SQN][k], 15'b0} + DVW'(root);
        dq_r[0][k]   <= '0;
      end
      dd_r[0] <= {root, 1'b0};
      dm_r[0] <= sm_r[SQN];
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int QI = QB - 1 - j;
    logic [DVW:0] dsub;
    assign dsub = (DVW+1)'(dd_r[j]) << QI;
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic ge;
      assign ge = ({1'b0, drem_r[j][k]} >= dsub);
      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[j+1][k] <= ge ? drem_r[j][k] - dsub[DVW-1:0] : drem_r[j][k];
          dq_r[j+1][k]   <= dq_r[j][k] | (ge ? QB'(1) << QI : '0);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dd_r[j+1] <= dd_r[j];
        dm_r[j+1] <= dm_r[j];
      end
    end
  end

  // clamp, sign and status into the output register
  logic [NORM_W-1:0] qc [3];
  logic [NORM_W-1:0] nv [3];
  tfn_out_t          res_r, res_nxt;
  logic              out_v_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (dq_r[QB][k] > NORM_ONE) ? NORM_ONE : dq_r[QB][k];
      nv[k] = dm_r[QB].neg[k] ? NORM_W'(-qc[k]) : qc[k];
      if (dm_r[QB].status != ST_OK) nv[k] = '0;
    end
    res_nxt.normal_x    = nv[0];
    res_nxt.normal_y    = nv[1];
    res_nxt.normal_z    = nv[2];
    res_nxt.status      = dm_r[QB].status;
    res_nxt.last_normal = dm_r[QB].last;
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end

  assign res       = res_r;
  assign res_valid = out_v_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0; v10_r <= 1'b0;
      for (int s = 0; s <= SQN; s++) sv_r[s] <= 1'b0;
      for (int j = 0; j <= QB; j++) dv_r[j] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= cmd_valid && cmd.is_tri;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      sv_r[0] <= v10_r;
      for (int s = 0; s < SQN; s++) sv_r[s+1] <= sv_r[s];
      dv_r[0] <= sv_r[SQN];
      for (int j = 0; j < QB; j++) dv_r[j+1] <= dv_r[j];
      out_v_r <= dv_r[QB];
    end
  end

endmodule

[hdl/triangle_face_normal.sv]
// ---------------------------------------------------------------------------
// triangle_face_normal: unit face normal of indexed triangles
// Loads fill a vertex store; triangle requests give a Q2.14 unit normal of
// b x a with a status. Front end classifies, a short queue decouples it from
// the back end that holds the store and the arithmetic pipeline.
//
//   channel   ports                          moves
//   input     in_push / in_full / in_req     one request per edge while not full
//   result    out_empty / out_pop / out_res  one result per triangle
//   config    cfg_we / cfg_wdata             flip_winding, no read-back
//
// One request per cycle sustained while results are taken; a triangle result
// passes the 31-stage square root and 16-stage dividers before it appears.
// The three store banks let the three corner reads happen in the same cycle.
// A waiting result freezes the back end; the two-entry queue then fills and
// in_full rises. Reset clears control only; the store is not cleared and
// holds no valid bits.
// ---------------------------------------------------------------------------
module triangle_face_normal import tfn_pkg::*; #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_BITS   = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  tfn_in_t  in_req,
  output logic     out_empty,
  input  logic     out_pop,
  output tfn_out_t out_res,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic     flip_winding_r;
  tfn_cmd_t fr_cmd, q_cmd;
  logic     fr_keep;
  logic     q_push, q_pop, q_empty;
  logic     res_valid;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) flip_winding_r <= 1'b0;
    else if (cfg_we) flip_winding_r <= cfg_wdata;
  end

  tfn_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .req  (in_req),
    .flip (flip_winding_r),
    .cmd  (fr_cmd),
    .keep (fr_keep)
  );

  assign q_push = in_push && !in_full && fr_keep;

  tfn_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (fr_cmd),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  tfn_back #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res_valid (res_valid),
    .res       (out_res),
    .res_pop   (out_pop)
  );

  assign out_empty = !res_valid;

  // error results carry a zero normal
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_res.status != ST_OK) |->
      (out_res.normal_x == '0 && out_res.normal_y == '0 && out_res.normal_z == '0))
    else $error("error result with nonzero normal");

  // back end holds the queue while a result waits
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |-> !q_pop)
    else $error("queue popped during output stall");

  // never pop an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
